>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

>>> design/firdec_pkg.sv
// ----------------------------------------------------------------------------
// firdec_pkg
// Shared types and constants of the decimating FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package firdec_pkg;

	// Q1.15 samples and coefficients
	localparam int SB = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PUSH = 1'b1;

	// register select, taken from paddr[2]
	localparam logic REG_DECIM_FACTOR = 1'b0;
	localparam logic REG_TAPS_IN_USE  = 1'b1;

	localparam logic [5:0] DECIM_RESET = 6'd10;
	localparam logic [7:0] TAPS_RESET  = 8'd51;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                 op;
		logic [6:0]           coeff_index;
		logic signed [SB-1:0] coeff_value;
		logic signed [SB-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SB-1:0] filtered;
		logic                 clipped;
	} out_item_t;

	typedef struct packed {
		logic load;    // write coefficient
		logic push;    // write sample, advance phase, clear accumulator
		logic issue;   // read one tap pair into the MAC pipe
		logic finish;  // shift, saturate and register the result
	} cmd_t;

	typedef struct packed {
		logic emit;       // current phase marks the pushed sample
		logic pipe_busy;  // MAC pipe still holds taps
		logic out_free;   // result register can take a new value
	} sts_t;

endpackage

`default_nettype wire

>>> design/fir_decimator_top.sv
// ----------------------------------------------------------------------------
// fir_decimator_top
// Decimating FIR filter, Q1.15 in and out, one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// A transaction with op = load writes one coefficient (index beyond the
// table is dropped); op = push shifts one sample into the delay line. Every
// decim_factor-th push (the first after reset included) produces one result:
// sum of coeff[k] * x[n-k] over taps_in_use taps, floor-shifted right by 15
// and saturated, with clipped set on saturation. Loads and unmarked pushes
// are taken without stall. After a marked push item_stall holds while the
// single MAC reads one tap pair per cycle from the coefficient and sample
// memories for taps pairs, taps being taps_in_use with zero read as one and
// clamped to MAX_TAPS, then drains a two-stage pipe, and longer while the
// previous result is still stalled; the result is then shifted, saturated
// and waits in an output register. Unwritten coefficients read as garbage.
// The delay line reads as zero until filled; no clearing pass.
// Config registers at byte offsets 0x0 (decim_factor) and 0x4
// (taps_in_use); write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_decimator_top
	import firdec_pkg::*;
#(
	parameter int MAX_TAPS = 128
) (
	input  wire logic     clk,
	input  wire logic     arst_n,

	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire in_item_t item,

	output logic          result_valid,
	input  wire logic     result_stall,
	output out_item_t     result,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IDX_W = $clog2(MAX_TAPS);
	localparam int TAP_W = $clog2(MAX_TAPS + 1);

	logic [5:0]       decim_q;
	logic [7:0]       taps_q;
	logic [TAP_W-1:0] taps_eff;
	logic             cfg_wr;
	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] tap_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_RESET;
			taps_q  <= TAPS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DECIM_FACTOR: decim_q <= pwdata[5:0];
				REG_TAPS_IN_USE:  taps_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DECIM_FACTOR: prdata = {26'd0, decim_q};
			REG_TAPS_IN_USE:  prdata = {24'd0, taps_q};
			default:          prdata = '0;
		endcase
	end

	// zero taps means one; anything past the table clamps to its depth
	always_comb begin
		if (taps_q == 8'd0) begin
			taps_eff = TAP_W'(1);
		end else if (int'(taps_q) > MAX_TAPS) begin
			taps_eff = TAP_W'(MAX_TAPS);
		end else begin
			taps_eff = TAP_W'(taps_q);
		end
	end

	firdec_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_stall (item_stall),
		.taps_eff   (taps_eff),
		.sts        (sts),
		.cmd        (cmd),
		.tap_idx    (tap_idx)
	);

	firdec_datapath #(
		.MAX_TAPS (MAX_TAPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.decim_factor (decim_q),
		.cmd          (cmd),
		.tap_idx      (tap_idx),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> design/firdec_ctrl.sv
// ----------------------------------------------------------------------------
// firdec_ctrl
// Sequencer: accepts transactions, steps the tap index, waits for the
// MAC pipe to drain and for room in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module firdec_ctrl
	import firdec_pkg::*;
#(
	parameter int MAX_TAPS = 128,
	localparam int IDX_W   = $clog2(MAX_TAPS),
	localparam int TAP_W   = $clog2(MAX_TAPS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_op,
	output logic                  item_stall,
	input  wire logic [TAP_W-1:0] taps_eff,
	input  wire sts_t             sts,
	output cmd_t                  cmd,
	output logic [IDX_W-1:0]      tap_idx
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  tap_q, tap_d;
	logic              last_tap;

	assign last_tap = (TAP_W'(tap_q) + TAP_W'(1)) == taps_eff;
	assign tap_idx  = tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else begin
			tap_q <= tap_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		tap_d      = tap_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (item_op == OP_PUSH) begin
						cmd.push = 1'b1;
						if (sts.emit) begin
							tap_d   = '0;
							state_d = ST_MAC;
						end
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				if (last_tap) begin
					state_d = ST_DRAIN;
				end else begin
					tap_d = tap_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_CLK(a_emit_starts_mac, clk, arst_n, (cmd.push && sts.emit) |=> (state_q == ST_MAC))
	`ASSERT_CLK(a_tap_in_range, clk, arst_n, (state_q == ST_MAC) |-> (TAP_W'(tap_q) < taps_eff))
	`ASSERT_CLK(a_drain_exit, clk, arst_n, (state_q == ST_DRAIN) |=> (state_q == ST_DRAIN || state_q == ST_IDLE))

endmodule

`default_nettype wire

>>> design/firdec_datapath.sv
// ----------------------------------------------------------------------------
// firdec_datapath
// Coefficient and sample memories, phase counter, MAC pipe and result
// register of the decimating FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module firdec_datapath
	import firdec_pkg::*;
#(
	parameter int MAX_TAPS = 128,
	localparam int IDX_W   = $clog2(MAX_TAPS),
	localparam int TAP_W   = $clog2(MAX_TAPS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_item_t         item,
	input  wire logic [5:0]       decim_factor,
	input  wire cmd_t             cmd,
	input  wire logic [IDX_W-1:0] tap_idx,
	output sts_t                  sts,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output out_item_t             result
);

	localparam int ACC_W = 2 * SB + $clog2(MAX_TAPS) + 1;
	localparam int SH_W  = ACC_W - SB + 1;

	logic signed [SB-1:0]   coeff_mem [MAX_TAPS];
	logic signed [SB-1:0]   dly_mem   [MAX_TAPS];

	logic [IDX_W-1:0]       wptr_q;
	logic [IDX_W-1:0]       rptr_q;
	logic [TAP_W-1:0]       fill_q;
	logic [5:0]             phase_q;
	logic [5:0]             decim_eff;
	logic                   load_ok;

	logic                   valid_s1, valid_s2;
	logic signed [SB-1:0]   coeff_s1, dly_s1;
	logic                   inrange_s1;
	logic signed [SB-1:0]   dly_use;
	logic signed [2*SB-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [SH_W-1:0] shifted;
	logic                   fits;
	logic                   result_valid_q;
	out_item_t              result_q;

	assign decim_eff = (decim_factor == 6'd0) ? 6'd1 : decim_factor;
	assign load_ok   = int'(item.coeff_index) < MAX_TAPS;

	assign sts.emit      = (phase_q == 6'd0);
	assign sts.pipe_busy = valid_s1 | valid_s2;
	assign sts.out_free  = !result_valid_q || !result_stall;

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			coeff_mem[IDX_W'(item.coeff_index)] <= item.coeff_value;
		end
		coeff_s1 <= coeff_mem[tap_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			dly_mem[wptr_q] <= item.sample;
		end
		dly_s1 <= dly_mem[rptr_q];
	end

	// circular delay line; fill count stands in for the zero reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			fill_q  <= '0;
			phase_q <= '0;
		end else begin
			if (cmd.push) begin
				rptr_q <= wptr_q;
				wptr_q <= (wptr_q == IDX_W'(MAX_TAPS - 1)) ? '0 : wptr_q + IDX_W'(1);
				if (fill_q != TAP_W'(MAX_TAPS)) begin
					fill_q <= fill_q + TAP_W'(1);
				end
				phase_q <= (({1'b0, phase_q} + 7'd1) >= {1'b0, decim_eff}) ?
					6'd0 : phase_q + 6'd1;
			end else if (cmd.issue) begin
				rptr_q <= (rptr_q == '0) ? IDX_W'(MAX_TAPS - 1) : rptr_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		inrange_s1 <= TAP_W'(tap_idx) < fill_q;
	end

	always_comb begin
		dly_use = inrange_s1 ? dly_s1 : SB'(0);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coeff_s1 * dly_use;
		if (cmd.push) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + {{(ACC_W - 2 * SB){prod_s2[2*SB-1]}}, prod_s2};
		end
	end

	// floor shift is a plain drop of the fraction bits
	assign shifted = acc_q[ACC_W-1:SB-1];
	assign fits    = (&shifted[SH_W-1:SB-1]) | ~(|shifted[SH_W-1:SB-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.clipped <= !fits;
			if (fits) begin
				result_q.filtered <= shifted[SB-1:0];
			end else begin
				result_q.filtered <= {shifted[SH_W-1], {(SB - 1){~shifted[SH_W-1]}}};
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_CLK(a_fill_bound, clk, arst_n, fill_q <= TAP_W'(MAX_TAPS))
	`ASSERT_CLK(a_finish_room, clk, arst_n, cmd.finish |-> (!result_valid_q || !result_stall))
	`ASSERT_NEVER(a_finish_pipe_empty, clk, arst_n, cmd.finish && (valid_s1 || valid_s2))

endmodule

`default_nettype wire
